FILE: src/dab_pkg.sv
`timescale 1ns / 1ps
// Package: shared types, codes and widths of the disk block allocator.
package dab_pkg;

  localparam int BLK_W   = 6;   // block number field
  localparam int CNT_W   = 7;   // block count / disk size field
  localparam int ID_W    = 8;   // file id field
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Allocation modes
  localparam logic [1:0] MODE_CONTIG  = 2'd0;
  localparam logic [1:0] MODE_LINKED  = 2'd1;
  localparam logic [1:0] MODE_INDEXED = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;  // rejects every allocate

  // Result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_INDEX  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_MAP    = 2'd3;

  // Request actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Register byte addresses
  localparam logic [PADDR_W-1:0] ADDR_MODE = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_DISK = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_REJECT,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // One result as held in the output register
  typedef struct packed {
    logic [1:0]       kind;
    logic [BLK_W-1:0] block;
    logic             block_used;
    logic [ID_W-1:0]  owner;
    logic             link_valid;
    logic [BLK_W-1:0] link_block;
    logic             last;
  } out_res_t;

  // Map entry word kept in RAM: link valid, link, owner
  typedef struct packed {
    logic             link_valid;
    logic [BLK_W-1:0] link_block;
    logic [ID_W-1:0]  owner;
  } map_word_t;

endpackage

FILE: src/dab_if.sv
`timescale 1ns / 1ps
// Interfaces: request and result channels of the disk block allocator.
interface dab_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] file_id;
  logic [6:0] block_count;
  logic [5:0] block_index;

  modport source (output valid, action, file_id, block_count, block_index, input ready);
  modport sink   (input valid, action, file_id, block_count, block_index, output ready);
endinterface

interface dab_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [5:0] block;
  logic       block_used;
  logic [7:0] owner;
  logic       link_valid;
  logic [5:0] link_block;
  logic       last;

  modport source (output valid, kind, block, block_used, owner, link_valid, link_block,
                  last, input ready);
  modport sink   (input valid, kind, block, block_used, owner, link_valid, link_block,
                  last, output ready);
endinterface

FILE: src/dab_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module dab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

FILE: src/disk_block_allocator_top.sv
`timescale 1ns / 1ps
// Top level: disk block allocator with contiguous, linked and indexed modes.
//
// Requests arrive on in_if (valid/ready). An allocate request asks for
// block_count blocks for file_id; a read request returns one map entry.
// Results leave on out_if (valid/ready), one per granted block in grant
// order, or one reject, or one map entry; the final one carries last.
// Registers (APB, pready always high): 0x0 alloc_mode, 0x4 disk_blocks.
// Writing disk_blocks clears the whole map at once (used flags in flops).
// Work per request: a read does one registered RAM read; an allocate
// examines blocks with the single scan pointer (up to disk size) and
// emits its results, using the one RAM write port per granted block.
// in_if.ready is high only while no request is in progress. If the
// receiver stalls, the result waits in the output register and the
// sequencer waits with it.
// After reset: mode contiguous, 64 blocks, every block free.
module disk_block_allocator_top #(
  parameter int NUM_BLOCKS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  dab_in_if.sink                        in_if,
  dab_out_if.source                     out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dab_pkg::PADDR_W-1:0]   paddr,
  input  logic [dab_pkg::PDATA_W-1:0]   pwdata,
  output logic [dab_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import dab_pkg::*;

  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam logic [CNT_W-1:0] NB = CNT_W'(NUM_BLOCKS);

  state_t                  state_r, state_nxt;
  logic [1:0]              mode_r, mode_nxt;
  logic [CNT_W-1:0]        disk_r, disk_nxt;
  logic [NUM_BLOCKS-1:0]   used_r, used_nxt;
  logic [CNT_W-1:0]        free_r, free_nxt;
  logic [ID_W-1:0]         id_r, id_nxt;
  logic [CNT_W-1:0]        need_r, need_nxt;
  logic [CNT_W-1:0]        k_r, k_nxt;
  logic [CNT_W-1:0]        ptr_r, ptr_nxt;
  logic [CNT_W-1:0]        run_r, run_nxt;
  logic [IW-1:0]           cur_r, cur_nxt;
  logic [IW-1:0]           nx_r, nx_nxt;
  logic                    have_r, have_nxt;
  logic [BLK_W-1:0]        idx_r, idx_nxt;
  logic                    ov_r, ov_nxt;
  out_res_t                res_r, res_nxt;

  logic                    cfg_wr, in_acc, out_free, take, ram_re;
  logic [IW-1:0]           ram_raddr, scan_idx;
  map_word_t               ram_wdata, ram_rdata;
  logic [CNT_W-1:0]        size, new_size;
  logic [CNT_W:0]          need_ext;
  logic                    rej, idx_in, last_b, lv_b, is_free;
  logic [IW-1:0]           start_b;

  function automatic logic [CNT_W-1:0] clamp(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > NB) r = NB;
    return r;
  endfunction

  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !ov_r || out_if.ready;
  assign size     = clamp(disk_r);
  assign new_size = clamp(pwdata[CNT_W-1:0]);
  assign scan_idx = ptr_r[IW-1:0];
  assign is_free  = !used_r[scan_idx];

  // Register readback
  always_comb begin
    prdata = '0;
    unique case (paddr)
      ADDR_MODE: prdata = PDATA_W'(mode_r);
      ADDR_DISK: prdata = PDATA_W'(disk_r);
      default:   prdata = '0;
    endcase
  end

  // Map store: owner and link per block
  dab_ram #(.WIDTH($bits(map_word_t)), .DEPTH(NUM_BLOCKS)) u_map (
    .clk   (clk),
    .we    (take),
    .waddr (cur_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_if.ready       = (state_r == ST_IDLE);
  assign out_if.valid      = ov_r;
  assign out_if.kind       = res_r.kind;
  assign out_if.block      = res_r.block;
  assign out_if.block_used = res_r.block_used;
  assign out_if.owner      = res_r.owner;
  assign out_if.link_valid = res_r.link_valid;
  assign out_if.link_block = res_r.link_block;
  assign out_if.last       = res_r.last;

  // Sequencer: next state and datapath
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    disk_nxt  = disk_r;
    used_nxt  = used_r;
    free_nxt  = free_r;
    id_nxt    = id_r;
    need_nxt  = need_r;
    k_nxt     = k_r;
    ptr_nxt   = ptr_r;
    run_nxt   = run_r;
    cur_nxt   = cur_r;
    nx_nxt    = nx_r;
    have_nxt  = have_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r && !out_if.ready;
    res_nxt   = res_r;
    take      = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = in_if.block_index[IW-1:0];
    need_ext  = '0;
    rej       = 1'b0;
    idx_in    = (idx_r < BLK_W'(NUM_BLOCKS)) || (NUM_BLOCKS >= 64);
    last_b    = (k_r + CNT_W'(1)) == need_r;
    lv_b      = (mode_r == MODE_LINKED) && !last_b;
    start_b   = (run_r == '0) ? scan_idx : cur_r;
    ram_wdata = '{link_valid: lv_b, link_block: lv_b ? BLK_W'(nx_r) : '0, owner: id_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          id_nxt   = in_if.file_id;
          idx_nxt  = in_if.block_index;
          ptr_nxt  = '0;
          run_nxt  = '0;
          k_nxt    = '0;
          have_nxt = 1'b0;
          if (in_if.action == ACT_READ) begin
            ram_re    = 1'b1;
            state_nxt = ST_READ;
          end else begin
            need_ext = (mode_r == MODE_INDEXED) ? ({1'b0, in_if.block_count} + 8'd1)
                                                : {1'b0, in_if.block_count};
            unique case (mode_r)
              MODE_CONTIG, MODE_LINKED:
                rej = (in_if.block_count == '0) || (need_ext > {1'b0, free_r});
              MODE_INDEXED: rej = need_ext > {1'b0, free_r};
              default:      rej = 1'b1;
            endcase
            need_nxt  = need_ext[CNT_W-1:0];
            state_nxt = rej ? ST_REJECT : ST_SCAN;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          ov_nxt              = 1'b1;
          res_nxt             = '0;
          res_nxt.kind        = KIND_MAP;
          res_nxt.block       = idx_r;
          res_nxt.last        = 1'b1;
          if (idx_in && used_r[idx_r[IW-1:0]]) begin
            res_nxt.block_used = 1'b1;
            res_nxt.owner      = ram_rdata.owner;
            res_nxt.link_valid = ram_rdata.link_valid;
            res_nxt.link_block = ram_rdata.link_block;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_REJECT: begin
        if (out_free) begin
          ov_nxt       = 1'b1;
          res_nxt      = '0;
          res_nxt.kind = KIND_REJECT;
          res_nxt.last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (mode_r == MODE_CONTIG) begin
          // First fit: track the current free run
          if (ptr_r >= size) begin
            state_nxt = ST_REJECT;
          end else begin
            ptr_nxt = ptr_r + CNT_W'(1);
            if (is_free) begin
              cur_nxt = start_b;
              run_nxt = run_r + CNT_W'(1);
              if ((run_r + CNT_W'(1)) == need_r) state_nxt = ST_EMIT;
            end else begin
              run_nxt = '0;
            end
          end
        end else begin
          // Lowest free block; one block of look-ahead for the link
          ptr_nxt = ptr_r + CNT_W'(1);
          if (is_free) begin
            if (!have_r) begin
              cur_nxt  = scan_idx;
              have_nxt = 1'b1;
              if (need_r == CNT_W'(1)) state_nxt = ST_EMIT;
            end else begin
              nx_nxt    = scan_idx;
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          take                = 1'b1;
          used_nxt[cur_r]     = 1'b1;
          free_nxt            = free_r - CNT_W'(1);
          k_nxt               = k_r + CNT_W'(1);
          ov_nxt              = 1'b1;
          res_nxt.kind        = ((mode_r == MODE_INDEXED) && (k_r == '0)) ? KIND_INDEX
                                                                          : KIND_DATA;
          res_nxt.block       = BLK_W'(cur_r);
          res_nxt.block_used  = 1'b1;
          res_nxt.owner       = id_r;
          res_nxt.link_valid  = lv_b;
          res_nxt.link_block  = lv_b ? BLK_W'(nx_r) : '0;
          res_nxt.last        = last_b;
          if (last_b) begin
            state_nxt = ST_IDLE;
          end else if (mode_r == MODE_CONTIG) begin
            cur_nxt = cur_r + IW'(1);
          end else begin
            cur_nxt = nx_r;
            if ((k_r + CNT_W'(2)) < need_r) state_nxt = ST_SCAN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Register writes (user must write only while idle; not enforced here)
    if (cfg_wr) begin
      if (paddr == ADDR_MODE) begin
        mode_nxt = pwdata[1:0];
      end else if (paddr == ADDR_DISK) begin
        disk_nxt = pwdata[CNT_W-1:0];
        used_nxt = '0;
        free_nxt = new_size;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= MODE_CONTIG;
      disk_r  <= CNT_W'(64);
      used_r  <= '0;
      free_r  <= clamp(CNT_W'(64));
      ov_r    <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      disk_r  <= disk_nxt;
      used_r  <= used_nxt;
      free_r  <= free_nxt;
      ov_r    <= ov_nxt;
      have_r  <= have_nxt;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    need_r <= need_nxt;
    k_r    <= k_nxt;
    ptr_r  <= ptr_nxt;
    run_r  <= run_nxt;
    cur_r  <= cur_nxt;
    nx_r   <= nx_nxt;
    idx_r  <= idx_nxt;
    res_r  <= res_nxt;
  end

`ifndef SYNTHESIS
  // Free count never exceeds NUM_BLOCKS
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= NB) else $error("free count above disk size");

  // A granted block was free when taken
  a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> !used_r[cur_r]) else $error("granted block already used");

  // A grant lowers the free count by one
  a_take_count: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> free_r == $past(free_r) - CNT_W'(1)) else $error("free count not decremented");

  // No new request while one is in progress
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_if.ready) else $error("request accepted while busy");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench: disk block allocator checked against a behavioral map predictor.
module testbench;
  import dab_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  dab_in_if in_if ();
  dab_out_if out_if ();

  disk_block_allocator_top u_top (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted disk map and registers
  logic [1:0]       mode_q;
  logic [6:0]       disk_q;
  logic [ID_W-1:0]  map_owner [64];
  logic             map_used [64];
  logic [BLK_W-1:0] map_link [64];
  logic             map_lv [64];
  int               free_blocks;
  out_res_t         expected_results[$];
  int               errors = 0;

  function automatic int disk_size();
    if (disk_q < 1) return 1;
    if (disk_q > 64) return 64;
    return disk_q;
  endfunction

  function automatic void clear_map();
    for (int i = 0; i < 64; i++) begin
      map_owner[i] = '0; map_used[i] = 1'b0; map_link[i] = '0; map_lv[i] = 1'b0;
    end
    free_blocks = disk_size();
  endfunction

  function automatic out_res_t entry(logic [1:0] k, int b, bit lst);
    out_res_t r;
    r.kind = k; r.block = b[5:0]; r.block_used = map_used[b]; r.owner = map_owner[b];
    r.link_valid = map_lv[b]; r.link_block = map_link[b]; r.last = lst;
    return r;
  endfunction

  // Append one expected result
  function automatic void queue_result(out_res_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic void push_reject();
    out_res_t r;
    r = '0; r.kind = KIND_REJECT; r.last = 1'b1;
    queue_result(r);
  endfunction

  function automatic void grab(int b, logic [7:0] id);
    map_used[b] = 1'b1; map_owner[b] = id; map_lv[b] = 1'b0; map_link[b] = '0;
    free_blocks--;
  endfunction

  // Work out the results of one request and update the map
  function automatic void predict_request(logic act, logic [7:0] id, logic [6:0] cnt,
                                          logic [5:0] idx);
    int sz, n, need, run, start, from, b;
    int got[64];
    bit indexed;
    sz = disk_size(); n = cnt;
    if (act == ACT_READ) begin
      queue_result(entry(KIND_MAP, idx, 1'b1));
      return;
    end
    if (mode_q == MODE_CONTIG) begin
      if (n == 0 || n > free_blocks) begin push_reject(); return; end
      run = 0; start = 0;
      for (int i = 0; i < sz; i++) begin
        if (map_used[i]) begin
          run = 0;
        end else begin
          if (run == 0) start = i;
          run++;
          if (run == n) begin
            for (int k = 0; k < n; k++) grab(start + k, id);
            for (int k = 0; k < n; k++)
              queue_result(entry(KIND_DATA, start + k, k + 1 == n));
            return;
          end
        end
      end
      push_reject();
      return;
    end
    if (mode_q != MODE_LINKED && mode_q != MODE_INDEXED) begin push_reject(); return; end
    indexed = (mode_q == MODE_INDEXED);
    need = indexed ? n + 1 : n;
    if (need == 0 || need > free_blocks || need > 64) begin push_reject(); return; end
    from = 0;
    for (int k = 0; k < need; k++) begin
      b = -1;
      for (int i = from; i < sz; i++)
        if (b < 0 && !map_used[i]) b = i;
      if (b < 0) begin push_reject(); return; end
      got[k] = b; from = b + 1;
    end
    for (int k = 0; k < need; k++) grab(got[k], id);
    if (!indexed)
      for (int k = 0; k + 1 < need; k++) begin
        map_lv[got[k]] = 1'b1; map_link[got[k]] = BLK_W'(got[k + 1]);
      end
    for (int k = 0; k < need; k++)
      queue_result(entry((indexed && k == 0) ? KIND_INDEX : KIND_DATA,
                         got[k], k + 1 == need));
  endfunction

  // Sender: bursts with random gaps; valid stays up inside a burst
  int burst_left = 0;

  task automatic send_request(logic act, logic [7:0] id, logic [6:0] cnt, logic [5:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_if.valid <= 1'b1; in_if.action <= act; in_if.file_id <= id;
    in_if.block_count <= cnt; in_if.block_index <= idx;
    do @(posedge clk); while (!in_if.ready);
    predict_request(act, id, cnt, idx);
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (140) @(negedge clk);
  endtask

  // Register write while idle
  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [31:0] data);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_MODE) begin
      mode_q = data[1:0];
    end else begin
      disk_q = data[6:0]; clear_map();
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Receiver stall pattern and result check
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase++;
    if (stall_phase % 400 < 150) out_if.ready <= 1'b1;
    else out_if.ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 3);
  end

  always @(posedge clk) begin
    out_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: kind %0d block %0d", out_if.kind, out_if.block);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_if.kind != want.kind) begin
          $error("kind: expected %0d got %0d", want.kind, out_if.kind); errors++; end
        if (out_if.block != want.block) begin
          $error("block: expected %0d got %0d", want.block, out_if.block); errors++; end
        if (out_if.block_used != want.block_used) begin
          $error("block_used: expected %0d got %0d", want.block_used, out_if.block_used);
          errors++; end
        if (out_if.owner != want.owner) begin
          $error("owner: expected %0d got %0d", want.owner, out_if.owner); errors++; end
        if (out_if.link_valid != want.link_valid) begin
          $error("link_valid: expected %0d got %0d", want.link_valid, out_if.link_valid);
          errors++; end
        if (out_if.link_block != want.link_block) begin
          $error("link_block: expected %0d got %0d", want.link_block, out_if.link_block);
          errors++; end
        if (out_if.last != want.last) begin
          $error("last: expected %0d got %0d", want.last, out_if.last); errors++; end
      end
    end
  end

  task automatic read_all(int upto);
    for (int i = 0; i < upto; i++)
      send_request(ACT_READ, 8'($urandom), 7'($urandom), i[5:0]);
  endtask

  // Directed: each mode, zero counts, full disk, unused mode, size extremes
  task automatic test_directed();
    send_request(ACT_ALLOC, 8'hFF, 7'd0, 6'd63);
    send_request(ACT_ALLOC, 8'h01, 7'd3, 6'd0);
    send_request(ACT_ALLOC, 8'h80, 7'd64, 6'd0);
    send_request(ACT_READ, 8'h00, 7'd127, 6'd63);
    send_request(ACT_READ, 8'h00, 7'd0, 6'd1);
    write_reg(ADDR_MODE, 32'(MODE_LINKED));
    send_request(ACT_ALLOC, 8'h02, 7'd0, 6'd0);
    send_request(ACT_ALLOC, 8'h02, 7'd4, 6'd0);
    send_request(ACT_READ, 8'h00, 7'd0, 6'd5);
    send_request(ACT_ALLOC, 8'h03, 7'd127, 6'd0);
    write_reg(ADDR_MODE, 32'(MODE_INDEXED));
    send_request(ACT_ALLOC, 8'h04, 7'd0, 6'd0);
    send_request(ACT_ALLOC, 8'h05, 7'd2, 6'd0);
    send_request(ACT_ALLOC, 8'h06, 7'd64, 6'd0);
    write_reg(ADDR_MODE, 32'(MODE_UNUSED));
    send_request(ACT_ALLOC, 8'h07, 7'd1, 6'd0);
    write_reg(ADDR_DISK, 32'd1);
    write_reg(ADDR_MODE, 32'(MODE_CONTIG));
    send_request(ACT_ALLOC, 8'h08, 7'd1, 6'd0);
    send_request(ACT_ALLOC, 8'h09, 7'd1, 6'd0);
    send_request(ACT_READ, 8'h00, 7'd0, 6'd0);
    send_request(ACT_READ, 8'h00, 7'd0, 6'd40);
    write_reg(ADDR_DISK, 32'd0);
    send_request(ACT_ALLOC, 8'h0A, 7'd1, 6'd0);
    write_reg(ADDR_DISK, 32'd127);
    send_request(ACT_ALLOC, 8'h0B, 7'd64, 6'd0);
  endtask

  // Random: sizes and modes vary per phase, mostly small allocations
  task automatic test_random();
    int sent;
    logic [6:0] cnt;
    sent = 0;
    while (sent < 320) begin
      if (sent % 40 == 0) begin
        write_reg(ADDR_MODE, $urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0: write_reg(ADDR_DISK, 32'd64);
          1: write_reg(ADDR_DISK, $urandom_range(1, 8));
          2: write_reg(ADDR_DISK, $urandom_range(65, 127));
          default: write_reg(ADDR_DISK, $urandom_range(9, 63));
        endcase
      end
      if ($urandom_range(0, 3) == 0) begin
        send_request(ACT_READ, 8'($urandom), 7'($urandom), 6'($urandom));
      end else begin
        cnt = ($urandom_range(0, 15) == 0) ? 7'($urandom) : 7'($urandom_range(0, 6));
        send_request(ACT_ALLOC, 8'($urandom), cnt, 6'($urandom));
      end
      sent++;
    end
    read_all(64);
  endtask

  initial begin
    in_if.valid = 1'b0; in_if.action = 1'b0; in_if.file_id = '0;
    in_if.block_count = '0; in_if.block_index = '0; out_if.ready = 1'b0;
    mode_q = MODE_CONTIG; disk_q = 7'd64; clear_map();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #60ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
